// ===== hdl/cc_cv_charge_regulator_core_assert.svh =====
// Assertion macros shared by the charge regulator RTL.
// No dependencies; included inside module bodies.
`ifndef CC_CV_CHARGE_REGULATOR_CORE_ASSERT_SVH
`define CC_CV_CHARGE_REGULATOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CCR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CCR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/ccr_pkg.sv =====
// Package for the charge regulator: constants, sequencer states, unit types.
// No dependencies.
`default_nettype none
package ccr_pkg;
   localparam int ADC_BITS = 12;
   localparam int unsigned DUTY_LO = 3277;
   localparam int unsigned DUTY_HI = 31457;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam logic [31:0] VSCALE_NUM = 32'd18022400;
   localparam logic [31:0] ISCALE_NUM = 32'd144900096;
   localparam logic [31:0] RAMP_STEP_Q32 = 32'd35799;

   localparam logic [2:0] REG_PERIOD = 3'd0;
   localparam logic [2:0] REG_VTARGET = 3'd1;
   localparam logic [2:0] REG_CLIMIT = 3'd2;
   localparam logic [2:0] REG_VKP = 3'd3;
   localparam logic [2:0] REG_VKI = 3'd4;
   localparam logic [2:0] REG_CKP = 3'd5;
   localparam logic [2:0] REG_CKI = 3'd6;
   localparam logic [2:0] REG_ALPHA = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VSCALE, ST_VDIV, ST_ISCALE, ST_IDIV,
      ST_VF1, ST_VF2, ST_IF1, ST_IF2, ST_RAMP,
      ST_VKI, ST_VKP, ST_CKI, ST_CKP, ST_PWM, ST_OUT
   } state_type;

   // Operands for the shared multiplier.
   typedef struct packed {
      logic signed [40:0] a;
      logic [31:0] b;
   } mul_op_type;
endpackage
`default_nettype wire

// ===== hdl/cc_cv_charge_regulator_core.sv =====
// Top level of the CC/CV charge regulator: sequencer, state and registers.
// Depends on ccr_pkg, ccr_mul and the assertion header.
//
// Each ADC sample pair, from transfer to result, runs through sixteen
// sequencer steps that pass every multiply through one shared multiplier, and
// the scaling divisions are reciprocal multiplies with one correction each.
// A button event is handled in the idle state and gives no result. req_tready is low
// while an item is in work or a result waits to be taken.
`default_nettype none
module cc_cv_charge_regulator_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [23:0] req_tdata,  // volt_raw[11:0], curr_raw[23:12]
   input  wire logic req_tuser,         // req_type
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [47:0] rsp_tdata,       // compare_value[15:0], running[16], curr_reference[40:17]
   input  wire logic csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   import ccr_pkg::*;
   `include "cc_cv_charge_regulator_core_assert.svh"

   localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};
   localparam logic [63:0] VDEN = 64'd2 * 64'(FULL);
   localparam logic [63:0] IDEN = 64'd40 * 64'(FULL);
   // Reciprocal scaled by 2^40, rounded down; quotient then corrected once.
   localparam logic [31:0] VREC = 32'((64'd1 << 40) / VDEN);
   localparam logic [31:0] IREC = 32'((64'd1 << 40) / IDEN);

   state_type state_ff, state_in;
   logic [15:0] period_ff;
   logic [23:0] vtarget_ff, climit_ff;
   logic [31:0] vkp_ff, vki_ff, ckp_ff, cki_ff;
   logic [16:0] alpha_ff;
   logic [31:0] vfilt_ff, vfilt_in, cfilt_ff, cfilt_in, ramp_ff, ramp_in;
   logic signed [31:0] vint_ff, vint_in, cint_ff, cint_in;
   logic en_ff, en_in;
   logic [ADC_BITS-1:0] iraw_ff;
   logic signed [40:0] acc_ff, acc_in;   // general scratch
   logic [31:0] num_ff, num_in;          // scaled sample
   logic signed [40:0] err_ff, err_in;
   logic [23:0] iref_ff, iref_in;
   logic [15:0] duty_ff, duty_in;
   logic rvalid_ff, rvalid_in;
   logic [47:0] rdata_ff, rdata_in;
   mul_op_type op;
   logic signed [73:0] prod;
   logic [16:0] alpha_c;
   logic signed [40:0] p24, lim, sum;
   logic [40:0] q40;
   logic [63:0] rem;

   ccr_mul u_mul (.clock(clock), .op(op), .prod_ff(prod));

   assign alpha_c = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign p24 = 41'(prod >>> 24);
   assign q40 = 41'(prod >>> 40);
   assign lim = 41'(climit_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd2832; vtarget_ff <= 24'd4718592; climit_ff <= 24'd327680;
         vkp_ff <= 32'd838861; vki_ff <= 32'd16781; ckp_ff <= 32'd838861;
         cki_ff <= 32'd25171; alpha_ff <= 17'd13107;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PERIOD:  period_ff <= csr_wdata[15:0];
            REG_VTARGET: vtarget_ff <= csr_wdata[23:0];
            REG_CLIMIT:  climit_ff <= csr_wdata[23:0];
            REG_VKP:     vkp_ff <= csr_wdata;
            REG_VKI:     vki_ff <= csr_wdata;
            REG_CKP:     ckp_ff <= csr_wdata;
            REG_CKI:     cki_ff <= csr_wdata;
            REG_ALPHA:   alpha_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready && !req_tuser) state_in = ST_VSCALE;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = state_type'(state_ff + 5'd1);
      endcase
   end

   // Multiplier operands per step
   always_comb begin
      op.a = '0;
      op.b = '0;
      unique case (state_ff)
         ST_IDLE:   begin op.a = 41'(req_tdata[ADC_BITS-1:0]); op.b = VSCALE_NUM; end
         ST_VSCALE: begin op.a = 41'(iraw_ff); op.b = ISCALE_NUM; end
         ST_VDIV:   begin op.a = acc_in; op.b = VREC; end
         ST_ISCALE: begin op.a = err_ff; op.b = IREC; end
         ST_IDIV:   begin op.a = 41'(alpha_c); op.b = num_ff; end
         ST_VF1:    begin op.a = 41'(ALPHA_ONE - alpha_c); op.b = vfilt_ff; end
         ST_VF2:    begin op.a = 41'(alpha_c); op.b = num_ff; end
         ST_IF1:    begin op.a = 41'(ALPHA_ONE - alpha_c); op.b = cfilt_ff; end
         ST_IF2:    begin op.a = 41'(vtarget_ff); op.b = RAMP_STEP_Q32; end
         ST_RAMP:   begin op.a = 41'(ramp_in) - 41'(vfilt_ff); op.b = vki_ff; end
         ST_VKI:    begin op.a = err_ff; op.b = vkp_ff; end
         ST_VKP:    begin op.a = 41'(iref_in) - 41'(cfilt_ff); op.b = cki_ff; end
         ST_CKI:    begin op.a = err_ff; op.b = ckp_ff; end
         ST_CKP:    begin op.a = 41'(duty_in); op.b = 32'(period_ff); end
         ST_PWM:    begin op.a = 41'(duty_ff); op.b = 32'(period_ff); end
         default: ;
      endcase
   end

   // Datapath updates per step
   always_comb begin
      vfilt_in = vfilt_ff; cfilt_in = cfilt_ff; ramp_in = ramp_ff;
      vint_in = vint_ff; cint_in = cint_ff; en_in = en_ff;
      acc_in = acc_ff; num_in = num_ff; err_in = err_ff;
      iref_in = iref_ff; duty_in = duty_ff;
      rvalid_in = rvalid_ff && !rsp_tready; rdata_in = rdata_ff;
      sum = '0; rem = '0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready && req_tuser) begin
            en_in = !en_ff;
            if (en_ff) begin ramp_in = '0; vint_in = '0; cint_in = '0; end
         end
         ST_VSCALE: acc_in = 41'(prod);                      // volt numerator
         ST_VDIV: begin
            err_in = 41'(prod);                               // curr numerator
            acc_in = acc_ff;
         end
         ST_ISCALE: begin
            // volt quotient with one correction
            rem = 64'(acc_ff) - 64'(q40) * VDEN;
            num_in = (rem >= VDEN) ? 32'(q40 + 41'd1) : 32'(q40);
            acc_in = err_ff;
         end
         ST_IDIV: begin
            rem = 64'(acc_ff) - 64'(q40) * IDEN;
            acc_in = 41'(num_ff);                             // scaled volt
            num_in = (rem >= IDEN) ? 32'(q40 + 41'd1) : 32'(q40);
         end
         ST_VF1: begin err_in = 41'(prod); num_in = num_ff; end
         ST_VF2: begin
            sum = 41'(prod) + err_ff;
            err_in = sum;
            num_in = 32'(acc_ff);
         end
         ST_IF1: begin
            vfilt_in = 32'(err_ff >>> 16);
            err_in = 41'(prod);
         end
         ST_IF2: begin
            err_in = 41'(prod) + err_ff;
         end
         ST_RAMP: begin
            cfilt_in = 32'(err_ff >>> 16);
            if (en_ff && (ramp_ff < 32'(vtarget_ff)))
               ramp_in = ramp_ff + 32'(prod >>> 32);
            err_in = 41'(ramp_in) - 41'(vfilt_ff);
         end
         ST_VKI: begin
            sum = 41'(vint_ff) + (en_ff ? p24 : 41'sd0);
            if (sum < -lim) sum = -lim;
            else if (sum > lim) sum = lim;
            vint_in = 32'(sum);
         end
         ST_VKP: begin
            sum = p24 + 41'(vint_ff);
            if (sum < 0) sum = '0;
            else if (sum > lim) sum = lim;
            iref_in = 24'(sum);
            err_in = sum - 41'(cfilt_ff);
         end
         ST_CKI: begin
            sum = 41'(cint_ff) + (en_ff ? p24 : 41'sd0);
            if (sum < -41'sd31457) sum = -41'sd31457;
            else if (sum > 41'sd31457) sum = 41'sd31457;
            cint_in = 32'(sum);
         end
         ST_CKP: begin
            sum = p24 + 41'(cint_ff);
            if (sum < $signed(41'(DUTY_LO))) sum = $signed(41'(DUTY_LO));
            else if (sum > $signed(41'(DUTY_HI))) sum = $signed(41'(DUTY_HI));
            duty_in = en_ff ? 16'(sum) : 16'(DUTY_LO);
         end
         ST_PWM: ;
         ST_OUT: begin
            rvalid_in = 1'b1;
            rdata_in = {7'd0, iref_ff, en_ff, 16'(prod >>> 16)};
         end
         default: ;
      endcase
   end

   // Capture raw current count on transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         iraw_ff <= req_tdata[ADC_BITS +: ADC_BITS];
      end
   end

   // Hold state and scratch
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; en_ff <= 1'b0; rvalid_ff <= 1'b0;
         vfilt_ff <= '0; cfilt_ff <= '0; ramp_ff <= '0; vint_ff <= '0; cint_ff <= '0;
      end else begin
         state_ff <= state_in; en_ff <= en_in; rvalid_ff <= rvalid_in;
         vfilt_ff <= vfilt_in; cfilt_ff <= cfilt_in; ramp_ff <= ramp_in;
         vint_ff <= vint_in; cint_ff <= cint_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; num_ff <= num_in; err_ff <= err_in;
      iref_ff <= iref_in; duty_ff <= duty_in; rdata_ff <= rdata_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = rdata_ff;

   `CCR_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `CCR_ASSERT_NXT(a_out_gives_rsp, clock, reset, state_ff == ST_OUT, rsp_tvalid)
   `CCR_ASSERT_IMP(a_vint_bound, clock, reset, 1'b1,
      (41'(vint_ff) <= lim) && (41'(vint_ff) >= -lim))
   `CCR_ASSERT_IMP(a_cint_bound, clock, reset, 1'b1,
      (cint_ff <= 32'sd31457) && (cint_ff >= -32'sd31457))
endmodule
`default_nettype wire

// ===== hdl/ccr_mul.sv =====
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on ccr_pkg.
`default_nettype none
module ccr_mul (
   input  wire logic clock,
   input  wire ccr_pkg::mul_op_type op,
   output logic signed [73:0] prod_ff
);
   import ccr_pkg::*;
   logic signed [73:0] prod_in;

   // Form the product, registered for the next step
   assign prod_in = 74'(op.a) * $signed({1'b0, op.b});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== tb/cc_cv_charge_regulator_core_test.sv =====
// Self-checking testbench for the CC/CV charge regulator core: streams ADC
// pairs and button events, predicts each result in fixed point and compares.
// Depends on ccr_pkg and cc_cv_charge_regulator_core.
`default_nettype none
module cc_cv_charge_regulator_core_test;
   import ccr_pkg::*;

   localparam int FULL = 4095;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   typedef struct packed {
      logic button;
      logic [11:0] curr_raw;
      logic [11:0] volt_raw;
   } sample_type;

   typedef struct packed {
      logic [23:0] curr_reference;
      logic running;
      logic [15:0] compare_value;
   } duty_type;

   cc_cv_charge_regulator_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor copy of registers and loop state
   logic [15:0] p_period;
   logic [23:0] p_vtarget, p_climit;
   logic [31:0] p_vkp, p_vki, p_ckp, p_cki;
   logic [16:0] p_alpha;
   logic [31:0] p_vfilt, p_ifilt, p_ramp;
   longint p_vint, p_iint;
   logic p_enabled;

   sample_type pending_items[$];
   duty_type expected_duty[$];
   int mismatches = 0;
   int burst_left = 0, gap_left = 0;
   int hold_off = 0;
   bit stall_phase = 0;
   bit p_enabled_planned = 1'b0;

   function automatic longint floor_shr24(longint v);
      return v >>> 24;
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] smooth(logic [31:0] prev, logic [31:0] x);
      longint unsigned a;
      a = p_alpha > ALPHA_ONE ? 65536 : p_alpha;
      return 32'((a * x + (65536 - a) * longint'(prev)) >> 16);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PERIOD: p_period = val[15:0];
         REG_VTARGET: p_vtarget = val[23:0];
         REG_CLIMIT: p_climit = val[23:0];
         REG_VKP: p_vkp = val;
         REG_VKI: p_vki = val;
         REG_CKP: p_ckp = val;
         REG_CKI: p_cki = val;
         default: p_alpha = val[16:0];
      endcase
   endtask

   // Advance the regulator model by one accepted transfer
   task automatic predict_duty(sample_type s);
      longint unsigned vx, ix;
      longint lim, errv, vi, iref, erri, ci, duty;
      duty_type r;
      if (s.button) begin
         p_enabled = ~p_enabled;
         if (!p_enabled) begin
            p_ramp = 0;
            p_vint = 0;
            p_iint = 0;
         end
         return;
      end
      vx = (longint'(s.volt_raw) * VSCALE_NUM) / (2 * FULL);
      ix = (longint'(s.curr_raw) * ISCALE_NUM) / (40 * FULL);
      p_vfilt = smooth(p_vfilt, 32'(vx));
      p_ifilt = smooth(p_ifilt, 32'(ix));
      if (p_enabled && p_ramp < p_vtarget)
         p_ramp = p_ramp + 32'((longint'(p_vtarget) * RAMP_STEP_Q32) >> 32);
      lim = p_climit;
      errv = longint'(p_ramp) - longint'(p_vfilt);
      vi = p_vint;
      if (p_enabled) vi += floor_shr24(longint'(p_vki) * errv);
      vi = clampl(vi, -lim, lim);
      p_vint = vi;
      iref = clampl(floor_shr24(longint'(p_vkp) * errv) + vi, 0, lim);
      erri = iref - longint'(p_ifilt);
      ci = p_iint;
      if (p_enabled) ci += floor_shr24(longint'(p_cki) * erri);
      ci = clampl(ci, -longint'(DUTY_HI), longint'(DUTY_HI));
      p_iint = ci;
      duty = clampl(floor_shr24(longint'(p_ckp) * erri) + ci, DUTY_LO, DUTY_HI);
      if (!p_enabled) duty = DUTY_LO;
      r.compare_value = 16'((duty * longint'(p_period)) >> 16);
      r.running = p_enabled;
      r.curr_reference = iref[23:0];
      expected_duty.push_back(r);
   endtask

   // Drive transfers in bursts with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_duty(pending_items.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(req_tvalid && req_tready && pending_items.size() == 0)) begin
               req_tvalid <= 1'b1;
               req_tdata <= {pending_items[0].curr_raw, pending_items[0].volt_raw};
               req_tuser <= pending_items[0].button;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check results; stall on a pattern of its own
   always @(posedge clock) begin
      duty_type got, exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[40:0];
            if (expected_duty.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               exp_r = expected_duty.pop_front();
               if (got.compare_value !== exp_r.compare_value ||
                   got.running !== exp_r.running ||
                   got.curr_reference !== exp_r.curr_reference) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: cmp %0d/%0d run %0b/%0b iref %0d/%0d",
                              exp_r.compare_value, got.compare_value, exp_r.running,
                              got.running, exp_r.curr_reference, got.curr_reference);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (stall_phase) begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_item(logic btn, logic [11:0] v, logic [11:0] c);
      sample_type s;
      s.button = btn;
      s.volt_raw = v;
      s.curr_raw = c;
      pending_items.push_back(s);
   endtask

   // Well-formed sequence: start if stopped, a run of samples, then optionally stop
   task automatic queue_session(int n, bit stop_after);
      int base;
      base = $urandom_range(0, 4095);
      if (!p_enabled_planned) queue_item(1'b1, 12'($urandom), 12'($urandom));
      p_enabled_planned = 1'b1;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(1'b0, 12'($urandom), 12'($urandom));
         else
            queue_item(1'b0, 12'(base + $urandom_range(0, 64)), 12'($urandom_range(0, 4095)));
      end
      if (stop_after) begin
         queue_item(1'b1, 12'($urandom), 12'($urandom));
         p_enabled_planned = 1'b0;
      end
   endtask

   task automatic drain();
      wait (pending_items.size() == 0);
      @(posedge clock);
      wait (expected_duty.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      p_period = 2832; p_vtarget = 4718592; p_climit = 327680;
      p_vkp = 838861; p_vki = 16781; p_ckp = 838861; p_cki = 25171;
      p_alpha = 13107;
      p_vfilt = 0; p_ifilt = 0; p_ramp = 0; p_vint = 0; p_iint = 0;
      p_enabled = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes while stopped and running
      queue_item(1'b0, 12'd0, 12'd0);
      queue_item(1'b0, 12'hFFF, 12'hFFF);
      queue_item(1'b0, 12'hAAA, 12'h555);
      queue_item(1'b1, 12'hFFF, 12'hFFF);
      queue_item(1'b0, 12'd0, 12'd0);
      queue_item(1'b0, 12'd0, 12'd0);
      queue_item(1'b0, 12'h555, 12'hAAA);
      queue_item(1'b0, 12'hFFF, 12'd0);
      queue_item(1'b0, 12'd0, 12'hFFF);
      queue_item(1'b1, 12'd0, 12'd0);
      queue_item(1'b0, 12'h800, 12'h100);
      drain();

      // Extremes: zero period, alpha over one, tiny target, huge gains
      write_reg(REG_PERIOD, 32'd0);
      write_reg(REG_ALPHA, 32'h1FFFF);
      write_reg(REG_VTARGET, 32'd100);
      write_reg(REG_CLIMIT, 32'hFFFFFF);
      write_reg(REG_VKP, 32'hFFFFFFFF);
      write_reg(REG_VKI, 32'hFFFFFFFF);
      write_reg(REG_CKP, 32'hFFFFFFFF);
      write_reg(REG_CKI, 32'hFFFFFFFF);
      p_enabled_planned = p_enabled;
      queue_session(8, 1'b1);
      drain();

      write_reg(REG_PERIOD, 32'hFFFF);
      write_reg(REG_ALPHA, 32'd0);
      write_reg(REG_VTARGET, 32'hFFFFFF);
      write_reg(REG_CLIMIT, 32'd0);
      write_reg(REG_VKP, 32'd0);
      write_reg(REG_VKI, 32'd0);
      write_reg(REG_CKP, 32'd0);
      write_reg(REG_CKI, 32'd0);
      queue_session(8, 1'b1);
      drain();

      // Random phases with random settings
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(REG_PERIOD, $urandom_range(1, 65535));
         write_reg(REG_ALPHA, $urandom_range(0, 4) == 0 ? 32'd65536 : $urandom_range(500, 65535));
         write_reg(REG_VTARGET, $urandom_range(0, 16777215));
         write_reg(REG_CLIMIT, $urandom_range(0, 16777215));
         write_reg(REG_VKP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24));
         write_reg(REG_VKI, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
         write_reg(REG_CKP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24));
         write_reg(REG_CKI, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
         stall_phase = ph[0];
         if (ph == 3) hold_off = 400;
         for (int k = 0; k < 4; k++) begin
            queue_session($urandom_range(5, 40), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) queue_item(1'b1, 12'($urandom), 12'($urandom));
         end
         p_enabled_planned = 1'b0;
         drain();
         if (p_enabled) begin
            queue_item(1'b1, 12'd0, 12'd0);
            drain();
         end
         p_enabled_planned = 1'b0;
      end
      // Reset values of period and alpha restored before closing
      write_reg(REG_PERIOD, 32'd2832);
      write_reg(REG_ALPHA, 32'd13107);
      for (int k = 0; k < 5; k++) queue_session(30, 1'b1);
      drain();

      if (mismatches == 0)
         $display("cc_cv_charge_regulator_core regression: pass");
      else
         $display("cc_cv_charge_regulator_core regression: fail");
      $finish;
   end

   initial begin
      #8000000;
      $display("cc_cv_charge_regulator_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== cc_cv_charge_regulator_core.f =====
+incdir+hdl
hdl/ccr_pkg.sv
hdl/ccr_mul.sv
hdl/cc_cv_charge_regulator_core.sv
tb/cc_cv_charge_regulator_core_test.sv
